// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define TCQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define TCQ_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/tcq_pkg.sv =====
// Types and constants for the two-class oldest-first queue.
`timescale 1ns / 1ps

package tcq_pkg;

    typedef enum logic [1:0] {
        KIND_ENQ    = 2'd0,
        KIND_OLDEST = 2'd1,
        KIND_TAKE_A = 2'd2,
        KIND_TAKE_B = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic [7:0] CLASS_A_CODE = 8'd67;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_status;

endpackage

// ===== rtl/two_class_oldest_first_queue.sv =====
// Top level of the two-class oldest-first queue.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: i_kind and
//   i_animal_code. Kinds: enqueue, remove oldest of either class, remove
//   class A, remove class B. Code 'C' goes to class A, anything else to B.
//   Output channel (o_out_valid / i_out_stall) returns one result per
//   request: status, removed entry (code, stamp, class) and both counts.
//   Result: registered, and presented in the cycle after the request is taken.
//   Throughput: one request per cycle while o_in_stall is low; every
//   operation touches only the heads and tails, and each FIFO memory is
//   read at its next head address every cycle with registered read data.
//   Stall: while a result waits under i_out_stall, o_in_stall is raised and
//   the result is held; when it is taken, a new request is taken in the
//   same cycle.
//   Reset (synchronous, active low): both FIFOs empty, the arrival counter
//   back at one, no result pending. The stores are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_class_oldest_first_queue #(
    parameter int DEPTH      = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tcq_pkg::t_kind             i_kind,
    input  logic [7:0]                 i_animal_code,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tcq_pkg::t_status           o_status,
    output logic [7:0]                 o_removed_code,
    output logic [31:0]                o_removed_stamp,
    output logic                       o_removed_class_b,
    output logic [$clog2(DEPTH+1)-1:0] o_count_a,
    output logic [$clog2(DEPTH+1)-1:0] o_count_b
);
    import tcq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int BW = STAMP_BITS + 8;

    // Arrival counter: advances only when an entry is really stored.
    logic [STAMP_BITS-1:0] r_next_stamp;

    // Result register.
    logic                  r_out_valid;
    t_status               r_status;
    logic [7:0]            r_code;
    logic [STAMP_BITS-1:0] r_stamp;
    logic                  r_class_b;
    logic [CW-1:0]         r_count_a;
    logic [CW-1:0]         r_count_b;

    logic                  w_accept;
    logic                  w_push_a;
    logic                  w_push_b;
    logic                  w_pop_a;
    logic                  w_pop_b;
    logic [STAMP_BITS-1:0] w_head_a;
    logic [BW-1:0]         w_head_b;
    logic [CW-1:0]         w_cnt_a;
    logic [CW-1:0]         w_cnt_b;
    t_fifo_status          w_stat_a;
    t_fifo_status          w_stat_b;
    logic [STAMP_BITS-1:0] w_age_diff;

    t_status               n_status;
    logic [7:0]            n_code;
    logic [STAMP_BITS-1:0] n_stamp;
    logic                  n_class_b;

    // Hold the request while a result still waits for the receiver.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Modular age compare: B is older when (stamp B - stamp A) is negative.
    assign w_age_diff = w_head_b[STAMP_BITS-1:0] - w_head_a;

    always_comb begin
        w_push_a  = 1'b0;
        w_push_b  = 1'b0;
        w_pop_a   = 1'b0;
        w_pop_b   = 1'b0;
        n_status  = ST_DONE;
        n_code    = '0;
        n_stamp   = '0;
        n_class_b = 1'b0;
        if (w_accept) begin
            unique case (i_kind)
                KIND_ENQ: begin
                    if (i_animal_code == CLASS_A_CODE) begin
                        w_push_a = !w_stat_a.full;
                        n_status = w_stat_a.full ? ST_FULL : ST_DONE;
                    end else begin
                        w_push_b = !w_stat_b.full;
                        n_status = w_stat_b.full ? ST_FULL : ST_DONE;
                    end
                end
                KIND_OLDEST: begin
                    priority if (!w_stat_a.empty && !w_stat_b.empty) begin
                        w_pop_b = w_age_diff[STAMP_BITS-1];
                        w_pop_a = !w_age_diff[STAMP_BITS-1];
                    end else if (!w_stat_a.empty) begin
                        w_pop_a = 1'b1;
                    end else if (!w_stat_b.empty) begin
                        w_pop_b = 1'b1;
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
                KIND_TAKE_A: begin
                    w_pop_a  = !w_stat_a.empty;
                    n_status = w_stat_a.empty ? ST_EMPTY : ST_DONE;
                end
                KIND_TAKE_B: begin
                    w_pop_b  = !w_stat_b.empty;
                    n_status = w_stat_b.empty ? ST_EMPTY : ST_DONE;
                end
                default: begin
                    n_status = ST_EMPTY;
                end
            endcase
            // Report the entry that leaves.
            if (w_pop_a) begin
                n_code  = CLASS_A_CODE;
                n_stamp = w_head_a;
            end else if (w_pop_b) begin
                n_code    = w_head_b[BW-1:STAMP_BITS];
                n_stamp   = w_head_b[STAMP_BITS-1:0];
                n_class_b = 1'b1;
            end
        end
    end

    tcq_fifo #(
        .DEPTH (DEPTH),
        .WIDTH (STAMP_BITS)
    ) u_fifo_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push_a),
        .i_push_data (r_next_stamp),
        .i_pop       (w_pop_a),
        .o_head_data (w_head_a),
        .o_count     (w_cnt_a),
        .o_status    (w_stat_a)
    );

    tcq_fifo #(
        .DEPTH (DEPTH),
        .WIDTH (BW)
    ) u_fifo_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push_b),
        .i_push_data ({i_animal_code, r_next_stamp}),
        .i_pop       (w_pop_b),
        .o_head_data (w_head_b),
        .o_count     (w_cnt_b),
        .o_status    (w_stat_b)
    );

    // Control: result valid and arrival counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_next_stamp <= STAMP_BITS'(1);
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_push_a || w_push_b) begin
                r_next_stamp <= r_next_stamp + 1'b1;
            end
        end
    end

    // Payload: load on accept, hold otherwise. Counts are those after the request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_code    <= n_code;
            r_stamp   <= n_stamp;
            r_class_b <= n_class_b;
            r_count_a <= w_cnt_a + CW'(w_push_a) - CW'(w_pop_a);
            r_count_b <= w_cnt_b + CW'(w_push_b) - CW'(w_pop_b);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_removed_code    = r_code;
    assign o_removed_stamp   = 32'(r_stamp);
    assign o_removed_class_b = r_class_b;
    assign o_count_a         = r_count_a;
    assign o_count_b         = r_count_b;

    // Checks
    `TCQ_ASSERT(a_accept_gives_result, i_clk, i_rst_n, w_accept |=> o_out_valid, "accepted request gave no result")
    `TCQ_NEVER(a_fill_overrun, i_clk, i_rst_n, (w_cnt_a > CW'(DEPTH)) || (w_cnt_b > CW'(DEPTH)), "FIFO count beyond depth")
    `TCQ_ASSERT(a_no_removed_on_fail, i_clk, i_rst_n, (o_out_valid && o_status != ST_DONE) |-> (o_removed_code == 8'd0 && !o_removed_class_b), "removed entry reported on failed request")
    `TCQ_ASSERT(a_stamp_only_on_push, i_clk, i_rst_n, !(w_push_a || w_push_b) |=> $stable(r_next_stamp), "arrival counter moved without a store")

endmodule

// ===== rtl/tcq_fifo.sv =====
// Circular FIFO with a memory store and a registered head entry.
`timescale 1ns / 1ps

module tcq_fifo #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_push_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_head_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output tcq_pkg::t_fifo_status      o_status
);
    import tcq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    r_tail;
    logic [CW-1:0]    r_count;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_byp_hit;
    logic [WIDTH-1:0] r_byp_data;

    logic [AW-1:0]    n_head;
    logic [AW-1:0]    n_tail;
    logic [CW-1:0]    n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_pop) begin
            n_head  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
        if (i_push) begin
            n_tail  = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
    end

    // Re-read the head slot every cycle; a write into it this cycle is bypassed.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_data;
        end
        r_rd_data  <= r_mem[n_head];
        r_byp_data <= i_push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_byp_hit <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_byp_hit <= i_push && (r_tail == n_head);
        end
    end

    assign o_head_data    = r_byp_hit ? r_byp_data : r_rd_data;
    assign o_count        = r_count;
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(DEPTH));

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the two-class oldest-first queue: random and directed requests.
`timescale 1ns / 1ps

module testbench;

    import tcq_pkg::*;

    localparam int FIFO_DEPTH  = 16;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 190;

    // One queued request, with the idle cycles the sender spends before offering it
    typedef struct {
        t_kind       kind;
        logic [7:0]  code;
        int unsigned gap;
    } shelter_request_t;

    // One result as the block should present it
    typedef struct {
        t_status     status;
        logic [7:0]  code;
        logic [31:0] stamp;
        logic        class_b;
        logic [4:0]  count_a;
        logic [4:0]  count_b;
    } shelter_result_t;

    typedef struct {
        logic [7:0]  code;
        logic [31:0] stamp;
    } class_b_entry_t;

    // Clock, reset and every block input start at a known value
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    t_kind      i_kind        = KIND_ENQ;
    logic [7:0] i_animal_code = 8'd0;
    logic       i_out_stall   = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    t_status     o_status;
    logic [7:0]  o_removed_code;
    logic [31:0] o_removed_stamp;
    logic        o_removed_class_b;
    logic [4:0]  o_count_a;
    logic [4:0]  o_count_b;

    // Requests waiting to be offered, and results waiting to arrive
    shelter_request_t request_backlog [$];
    shelter_result_t  awaited_results [$];

    // Own copy of the shelter state: both FIFOs and the arrival counter
    logic [31:0]    class_a_stamps [$];
    class_b_entry_t class_b_entries [$];
    logic [31:0]    arrival_next = 32'd1;

    int unsigned mismatches = 0;

    // Idle ranges for the current phase; the stimulus block sets them at the start and then at falling edges
    int unsigned send_gap_max = 0;
    int unsigned recv_gap_max = 0;

    // Long receiver hold-off, asked for by bumping hold_ask
    int unsigned hold_ask  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    // Driver-private state
    logic             armed = 1'b0;
    shelter_request_t armed_req;
    int unsigned      gap_left = 0;

    // Receiver-private state
    int unsigned stall_left = 0;

    two_class_oldest_first_queue dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_animal_code     (i_animal_code),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_removed_code    (o_removed_code),
        .o_removed_stamp   (o_removed_stamp),
        .o_removed_class_b (o_removed_class_b),
        .o_count_a         (o_count_a),
        .o_count_b         (o_count_b)
    );

    always #6 i_clk = ~i_clk;

    // Work out the result of one accepted request and advance the shelter state.
    // Class A holds code 'C' only; every other code lands in class B.
    function automatic void predict_shelter_result(input t_kind kind, input logic [7:0] code);
        shelter_result_t res;
        class_b_entry_t  ent;
        logic [31:0]     age_gap;
        logic            take_a;
        logic            take_b;
        res.status  = ST_DONE;
        res.code    = 8'd0;
        res.stamp   = 32'd0;
        res.class_b = 1'b0;
        take_a      = 1'b0;
        take_b      = 1'b0;
        case (kind)
            KIND_ENQ: begin
                if (code == CLASS_A_CODE) begin
                    // full FIFO: drop the entry and keep the counter where it is
                    if (class_a_stamps.size() >= FIFO_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        class_a_stamps.push_back(arrival_next);
                        arrival_next = arrival_next + 32'd1;
                    end
                end else begin
                    if (class_b_entries.size() >= FIFO_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        ent.code  = code;
                        ent.stamp = arrival_next;
                        class_b_entries.push_back(ent);
                        arrival_next = arrival_next + 32'd1;
                    end
                end
            end
            KIND_TAKE_A: take_a = (class_a_stamps.size() != 0);
            KIND_TAKE_B: take_b = (class_b_entries.size() != 0);
            default: begin
                // oldest of either: with both heads present, compare stamps modulo 2^32
                if (class_a_stamps.size() != 0 && class_b_entries.size() != 0) begin
                    age_gap = class_b_entries[0].stamp - class_a_stamps[0];
                    take_b  = age_gap[31];
                    take_a  = !age_gap[31];
                end else begin
                    take_a = (class_a_stamps.size() != 0);
                    take_b = (class_b_entries.size() != 0);
                end
            end
        endcase
        if (take_a) begin
            res.code  = CLASS_A_CODE;
            res.stamp = class_a_stamps.pop_front();
        end else if (take_b) begin
            ent         = class_b_entries.pop_front();
            res.code    = ent.code;
            res.stamp   = ent.stamp;
            res.class_b = 1'b1;
        end else if (kind != KIND_ENQ) begin
            res.status = ST_EMPTY;
        end
        res.count_a = 5'(class_a_stamps.size());
        res.count_b = 5'(class_b_entries.size());
        awaited_results.push_back(res);
    endfunction

    // Queue one request, drawing its lead-in gap from the current phase's range
    task automatic queue_request(input t_kind kind, input logic [7:0] code);
        shelter_request_t req;
        req.kind = kind;
        req.code = code;
        req.gap  = $urandom_range(0, send_gap_max);
        request_backlog.push_back(req);
    endtask

    // Random request: enq_pct percent enqueues, class_a_pct percent of codes forced to 'C'
    task automatic queue_random_request(input int unsigned enq_pct, input int unsigned class_a_pct);
        t_kind      kind;
        logic [7:0] code;
        if ($urandom_range(0, 99) < enq_pct) begin
            kind = KIND_ENQ;
        end else begin
            kind = t_kind'($urandom_range(1, 3));
        end
        if ($urandom_range(0, 99) < class_a_pct) begin
            code = CLASS_A_CODE;
        end else begin
            code = 8'($urandom_range(0, 255));
        end
        queue_request(kind, code);
    endtask

    // Driver: predict on every accepted request, hold a stalled one, then offer the next
    // after its gap. A request that follows back to back keeps valid high without a dip.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            armed = 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_shelter_result(i_kind, i_animal_code);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (!armed && request_backlog.size() != 0) begin
                    armed_req = request_backlog.pop_front();
                    gap_left = armed_req.gap;
                    armed = 1'b1;
                end
                if (armed && gap_left == 0) begin
                    i_in_valid    <= 1'b1;
                    i_kind        <= armed_req.kind;
                    i_animal_code <= armed_req.code;
                    armed = 1'b0;
                end else begin
                    i_in_valid <= 1'b0;
                    if (armed) begin
                        gap_left = gap_left - 1;
                    end
                end
            end
        end
    end

    // Long hold-off counter, kept in its own process
    always @(posedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: stall for a drawn number of cycles per result, or throughout a hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                stall_left = $urandom_range(0, recv_gap_max);
            end
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left = stall_left - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Monitor: compare every taken result with the oldest awaited one
    always @(posedge i_clk) begin
        shelter_result_t want;
        logic            bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with no request outstanding: status %0d code %0d",
                             $realtime, o_status, o_removed_code);
                end
            end else begin
                want = awaited_results.pop_front();
                bad  = (o_status !== want.status) || (o_removed_code !== want.code)
                    || (o_removed_stamp !== want.stamp) || (o_removed_class_b !== want.class_b)
                    || (o_count_a !== want.count_a) || (o_count_b !== want.count_b);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: mismatch: expected st %0d code %0d stamp %0d b %0b a# %0d b# %0d",
                                 $realtime, want.status, want.code, want.stamp, want.class_b,
                                 want.count_a, want.count_b);
                        $display("%0t:           actual   st %0d code %0d stamp %0d b %0b a# %0d b# %0d",
                                 $realtime, o_status, o_removed_code, o_removed_stamp,
                                 o_removed_class_b, o_count_a, o_count_b);
                    end
                end
            end
        end
    end

    // Stimulus: directed opening, then random phases with their own mix and idle ranges
    initial begin
        int unsigned enq_pct   [PHASES] = '{85, 30, 70, 70, 50, 20, 60, 50};
        int unsigned a_pct     [PHASES] = '{50, 50, 80, 10, 50, 40, 50, 30};
        int unsigned send_max  [PHASES] = '{ 0, 19, 19,  0, 19,  0, 19,  0};
        int unsigned recv_max  [PHASES] = '{ 0, 19,  0, 19, 19,  0, 19, 19};

        // Directed: removals from an empty shelter of every kind
        send_gap_max = 0;
        recv_gap_max = 19;
        queue_request(KIND_OLDEST, 8'd0);
        queue_request(KIND_TAKE_A, 8'd255);
        queue_request(KIND_TAKE_B, 8'd67);
        // Code extremes and the neighbours of 'C'
        queue_request(KIND_ENQ, CLASS_A_CODE);
        queue_request(KIND_ENQ, 8'd0);
        queue_request(KIND_ENQ, 8'd255);
        queue_request(KIND_ENQ, CLASS_A_CODE);
        queue_request(KIND_ENQ, 8'd66);
        queue_request(KIND_ENQ, 8'd68);
        // Oldest with both heads present picks each class in turn; then the targeted kinds,
        // a targeted removal from an empty class, oldest with one side empty, and all empty
        queue_request(KIND_OLDEST, 8'd0);
        queue_request(KIND_OLDEST, 8'd0);
        queue_request(KIND_TAKE_B, 8'd0);
        queue_request(KIND_TAKE_A, 8'd0);
        queue_request(KIND_OLDEST, 8'd0);
        queue_request(KIND_TAKE_A, 8'd0);
        queue_request(KIND_OLDEST, 8'd0);
        queue_request(KIND_OLDEST, 8'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_backlog.size() != 0) @(negedge i_clk);

        for (int p = 0; p < PHASES; p++) begin
            @(negedge i_clk);
            send_gap_max = send_max[p];
            recv_gap_max = recv_max[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                queue_random_request(enq_pct[p], a_pct[p]);
            end
            // hold the receiver off while the sender keeps offering back to back
            if (p == 3) begin
                hold_ask++;
            end
            while (request_backlog.size() != 0) @(negedge i_clk);
        end

        // Drain: last request taken and every result in, then wait quietly before the verdict
        while (armed || i_in_valid || awaited_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Give up well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
